FILE: hw/rtl/pfa_pkg.sv
// shared types, kind codes and helpers for the physical memory frame allocator
// no dependencies; used by the top level and the frame map unit
package pfa_pkg;

    localparam int ROW_BITS = 32;
    localparam int ROW_IW   = 5;

    localparam logic [2:0] KIND_READ      = 3'd0;
    localparam logic [2:0] KIND_WRITE     = 3'd1;
    localparam logic [2:0] KIND_ALLOC     = 3'd2;
    localparam logic [2:0] KIND_RESERVE   = 3'd3;
    localparam logic [2:0] KIND_RESET_MAP = 3'd4;

    localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

    typedef struct packed {
        logic alloc;
        logic clear;
    } t_fa_cmd;

    typedef struct packed {
        logic        ready;
        logic        done;
        logic        failed;
        logic [31:0] frame;
    } t_fa_rsp;

    // lowest clear bit of a map row: {found, index}
    function automatic logic [ROW_IW:0] first_zero(input logic [ROW_BITS-1:0] row);
        logic [ROW_IW:0] r;
        r = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--) begin
            if (!row[i]) begin
                r = {1'b1, ROW_IW'(i)};
            end
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/pfa_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module pfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/pfa_frame_map.sv
// frame map held in 32-bit rows of a ram, row scan for the lowest free frame
// depends on pfa_pkg and pfa_ram
module pfa_frame_map #(
    parameter int FRAME_COUNT   = 64,
    parameter int KERNEL_FRAMES = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pfa_pkg::t_fa_cmd i_cmd,
    output pfa_pkg::t_fa_rsp o_rsp
);
    import pfa_pkg::*;

    localparam int ROWS      = (FRAME_COUNT + ROW_BITS - 1) / ROW_BITS;
    localparam int RAW       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int KROW      = KERNEL_FRAMES / ROW_BITS;
    localparam int START_ROW = (KROW < ROWS) ? KROW : ROWS - 1;

    localparam logic [1:0] F_INIT = 2'd0;
    localparam logic [1:0] F_IDLE = 2'd1;
    localparam logic [1:0] F_SCAN = 2'd2;
    localparam logic [1:0] F_CLR  = 2'd3;

    // kernel frames and slots past the last frame read as used
    function automatic logic [ROW_BITS-1:0] row_init(input logic [RAW-1:0] row);
        logic [ROW_BITS-1:0] v;
        int                  idx;
        for (int b = 0; b < ROW_BITS; b++) begin
            idx  = int'(row) * ROW_BITS + b;
            v[b] = (idx < KERNEL_FRAMES) || (idx >= FRAME_COUNT);
        end
        return v;
    endfunction

    logic [1:0]          r_state, n_state;
    logic [RAW-1:0]      r_row, n_row;
    logic                ram_we, ram_re;
    logic [RAW-1:0]      ram_waddr, ram_raddr;
    logic [ROW_BITS-1:0] ram_wdata, ram_rdata;
    logic [ROW_IW:0]     fz;
    logic                last_row;

    pfa_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign fz       = first_zero(ram_rdata);
    assign last_row = (r_row == RAW'(ROWS - 1));

    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        ram_we       = 1'b0;
        ram_waddr    = r_row;
        ram_wdata    = row_init(r_row);
        ram_re       = 1'b0;
        ram_raddr    = r_row;
        o_rsp.ready  = (r_state == F_IDLE);
        o_rsp.done   = 1'b0;
        o_rsp.failed = 1'b0;
        o_rsp.frame  = '0;
        case (r_state)
            F_INIT, F_CLR: begin
                ram_we = 1'b1;
                n_row  = r_row + RAW'(1);
                if (last_row) begin
                    n_state    = F_IDLE;
                    n_row      = '0;
                    o_rsp.done = (r_state == F_CLR);
                end
            end
            F_IDLE: begin
                if (i_cmd.alloc) begin
                    ram_re    = 1'b1;
                    ram_raddr = RAW'(START_ROW);
                    n_row     = RAW'(START_ROW);
                    n_state   = F_SCAN;
                end else if (i_cmd.clear) begin
                    n_row   = '0;
                    n_state = F_CLR;
                end
            end
            F_SCAN: begin
                if (fz[ROW_IW]) begin
                    ram_we      = 1'b1;
                    ram_wdata   = ram_rdata | (ROW_BITS'(1) << fz[ROW_IW-1:0]);
                    o_rsp.done  = 1'b1;
                    o_rsp.frame = 32'({r_row, fz[ROW_IW-1:0]});
                    n_state     = F_IDLE;
                end else if (last_row) begin
                    o_rsp.done   = 1'b1;
                    o_rsp.failed = 1'b1;
                    o_rsp.frame  = ALL_ONES;
                    n_state      = F_IDLE;
                end else begin
                    // next row read goes out while this one is checked
                    ram_re    = 1'b1;
                    ram_raddr = r_row + RAW'(1);
                    n_row     = r_row + RAW'(1);
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_INIT;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
        end
    end

endmodule

FILE: hw/rtl/physical_memory_frame_allocator.sv
// Word memory with a bitmap page-frame allocator and a kernel table pointer.
// After reset the block clears the word memory, one word a cycle, and takes no
// item until that is done. Then one item is in work at a time: a write, a
// reserve, an unknown kind or an out-of-range read goes straight to the result
// register, an in-range read waits for the registered memory read, an allocate
// scans the map, one row of 32 frames after another, and a reset map rewrites
// every map row, one map row rewritten a cycle. A new item is taken while the
// last result still waits in the output register; a finished result that finds
// that register still full holds there, so result-side stalls hold up the next item.
// depends on pfa_pkg, pfa_ram and pfa_frame_map
module physical_memory_frame_allocator #(
    parameter int MEM_WORDS          = 4096,
    parameter int FRAME_COUNT        = 64,
    parameter int KERNEL_FRAMES      = 8,
    parameter int KERNEL_TABLE_WORDS = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [95:0] i_s_axis_tdata,   // address, data, reserve count
    input  logic [2:0]  i_s_axis_tuser,   // kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // value
    output logic [0:0]  o_m_axis_tuser    // failed
);
    import pfa_pkg::*;

    localparam int MAW = $clog2(MEM_WORDS);
    localparam int TW  = $clog2(KERNEL_TABLE_WORDS + 1);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RDMEM = 3'd2;
    localparam logic [2:0] S_FRAME = 3'd3;
    localparam logic [2:0] S_PUT   = 3'd4;

    logic [2:0]     r_state, n_state;
    logic [MAW-1:0] r_clr, n_clr;
    logic [TW-1:0]  r_table_next, n_table_next;
    logic [31:0]    r_res_value, n_res_value;
    logic           r_res_failed, n_res_failed;
    logic           r_out_valid, n_out_valid;
    logic [31:0]    r_out_value, n_out_value;
    logic           r_out_failed, n_out_failed;

    logic           accept, in_range, slot_free;
    logic [31:0]    in_address, in_data, in_count;
    logic [32:0]    sum;
    logic           mem_we, mem_re;
    logic [MAW-1:0] mem_waddr, mem_raddr;
    logic [31:0]    mem_wdata, mem_rdata;
    t_fa_cmd        fa_cmd;
    t_fa_rsp        fa_rsp;

    pfa_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    pfa_frame_map #(
        .FRAME_COUNT   (FRAME_COUNT),
        .KERNEL_FRAMES (KERNEL_FRAMES)
    ) u_frame_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (fa_cmd),
        .o_rsp   (fa_rsp)
    );

    assign in_address      = i_s_axis_tdata[31:0];
    assign in_data         = i_s_axis_tdata[63:32];
    assign in_count        = i_s_axis_tdata[95:64];
    assign o_s_axis_tready = (r_state == S_IDLE) && fa_rsp.ready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign in_range        = (in_address < 32'(MEM_WORDS));
    assign sum             = {1'b0, in_count} + 33'(r_table_next);
    assign slot_free       = !r_out_valid || i_m_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = r_out_failed;

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_table_next = r_table_next;
        n_res_value  = r_res_value;
        n_res_failed = r_res_failed;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_value  = r_out_value;
        n_out_failed = r_out_failed;
        mem_we       = 1'b0;
        mem_waddr    = in_address[MAW-1:0];
        mem_wdata    = in_data;
        mem_re       = 1'b0;
        mem_raddr    = in_address[MAW-1:0];
        fa_cmd       = '0;
        case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + MAW'(1);
                if (r_clr == MAW'(MEM_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_res_value  = ALL_ONES;
                    n_res_failed = 1'b1;
                    n_state      = S_PUT;
                    case (i_s_axis_tuser)
                        KIND_READ: begin
                            if (in_range) begin
                                mem_re  = 1'b1;
                                n_state = S_RDMEM;
                            end
                        end
                        KIND_WRITE: begin
                            if (in_range) begin
                                mem_we       = 1'b1;
                                n_res_value  = '0;
                                n_res_failed = 1'b0;
                            end
                        end
                        KIND_ALLOC: begin
                            fa_cmd.alloc = 1'b1;
                            n_state      = S_FRAME;
                        end
                        KIND_RESERVE: begin
                            // full-width sum, no wrap on a huge count
                            if (sum <= 33'(KERNEL_TABLE_WORDS)) begin
                                n_res_value  = 32'(r_table_next);
                                n_res_failed = 1'b0;
                                n_table_next = sum[TW-1:0];
                            end
                        end
                        KIND_RESET_MAP: begin
                            fa_cmd.clear = 1'b1;
                            n_state      = S_FRAME;
                        end
                        default: begin
                            n_state = S_PUT;
                        end
                    endcase
                end
            end
            S_RDMEM: begin
                n_res_value  = mem_rdata;
                n_res_failed = 1'b0;
                n_state      = S_PUT;
            end
            S_FRAME: begin
                if (fa_rsp.done) begin
                    n_res_value  = fa_rsp.frame;
                    n_res_failed = fa_rsp.failed;
                    n_state      = S_PUT;
                end
            end
            S_PUT: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_res_value;
                    n_out_failed = r_res_failed;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_clr        <= '0;
            r_table_next <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_table_next <= n_table_next;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_value  <= n_res_value;
        r_res_failed <= n_res_failed;
        r_out_value  <= n_out_value;
        r_out_failed <= n_out_failed;
    end

endmodule

FILE: hw/rtl/pfa_checker.sv
// port-level checks for the physical memory frame allocator, bound to the top
// no package dependencies; watches the top level's ports only
module pfa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [0:0]  o_m_axis_tuser
);

    logic [1:0] r_pend;
    logic       in_acc, out_acc;

    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc = o_m_axis_tvalid && i_m_axis_tready;

    // items taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 2'(in_acc) - 2'(out_acc);
        end
    end

    a_no_item_during_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready)
        else $error("item port ready right after reset");

    a_fail_all_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == 32'hffff_ffff))
        else $error("failed item without all-ones value");

    a_no_invented_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_pend != 2'd0))
        else $error("result item with no item outstanding");

    a_bounded_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend != 2'd3))
        else $error("more than two items outstanding");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result item changed");

endmodule

bind physical_memory_frame_allocator pfa_checker u_pfa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

FILE: sim/physical_memory_frame_allocator_tb.sv
// testbench for the physical memory frame allocator: drives kind/address/data/count items,
// predicts every result with its own copy of memory, frame map and table pointer
// depends on pfa_pkg and the physical_memory_frame_allocator rtl
`timescale 1ns / 100ps

module physical_memory_frame_allocator_tb;

    import pfa_pkg::*;

    localparam int MEM_WORDS          = 4096;
    localparam int FRAME_COUNT        = 64;
    localparam int KERNEL_FRAMES      = 8;
    localparam int KERNEL_TABLE_WORDS = 512;

    localparam logic [2:0] KIND_LAST_CODE = 3'd7;
    localparam int RANDOM_ITEMS = 520;

    typedef struct packed {
        logic [31:0] value;
        logic        failed;
    } t_outcome;

    class frame_alloc_scoreboard;
        logic [31:0] mem_words [MEM_WORDS];
        bit          frame_used [FRAME_COUNT];
        int unsigned table_next;
        t_outcome    outcome_q [$];
        int          errors;

        function new();
            foreach (mem_words[i]) mem_words[i] = '0;
            rebuild_map();
            table_next = 0;
            errors = 0;
        endfunction

        function void rebuild_map();
            foreach (frame_used[f]) frame_used[f] = (f < KERNEL_FRAMES);
        endfunction

        function int unsigned table_room();
            return KERNEL_TABLE_WORDS - table_next;
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // work out the result of one accepted item and update the state copy
        function void note_item(logic [2:0] kind, logic [31:0] addr, logic [31:0] wdata,
                                logic [31:0] count);
            t_outcome res;
            bit       found;
            res = '{value: ALL_ONES, failed: 1'b1};
            found = 0;
            case (kind)
                KIND_READ: begin
                    if (addr < MEM_WORDS) res = '{value: mem_words[addr], failed: 1'b0};
                end
                KIND_WRITE: begin
                    if (addr < MEM_WORDS) begin
                        mem_words[addr] = wdata;
                        res = '{value: '0, failed: 1'b0};
                    end
                end
                KIND_ALLOC: begin
                    for (int f = KERNEL_FRAMES; f < FRAME_COUNT && !found; f++) begin
                        if (!frame_used[f]) begin
                            frame_used[f] = 1;
                            found = 1;
                            res = '{value: 32'(f), failed: 1'b0};
                        end
                    end
                end
                KIND_RESERVE: begin
                    // bound check at 64 bits so a huge count cannot wrap
                    if (64'(table_next) + 64'(count) <= 64'(KERNEL_TABLE_WORDS)) begin
                        res = '{value: table_next, failed: 1'b0};
                        table_next += count;
                    end
                end
                KIND_RESET_MAP: begin
                    rebuild_map();
                    res = '{value: '0, failed: 1'b0};
                end
                default: ;
            endcase
            outcome_q.push_back(res);
        endfunction

        task check_result(logic [31:0] value, logic failed);
            t_outcome want;
            if (outcome_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result value=%h failed=%b", value, failed));
                return;
            end
            want = outcome_q.pop_front();
            if (value !== want.value)
                report_mismatch($sformatf("value %h, want %h", value, want.value));
            if (failed !== want.failed)
                report_mismatch($sformatf("failed %b, want %b", failed, want.failed));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [95:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    frame_alloc_scoreboard board;
    int  items_sent;
    bit  send_calm;
    bit  recv_calm;
    logic [31:0] written_addrs [$];

    physical_memory_frame_allocator #(
        .MEM_WORDS          (MEM_WORDS),
        .FRAME_COUNT        (FRAME_COUNT),
        .KERNEL_FRAMES      (KERNEL_FRAMES),
        .KERNEL_TABLE_WORDS (KERNEL_TABLE_WORDS)
    ) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tdata),   // address, data, reserve count
        .i_s_axis_tuser  (s_tuser),   // kind
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata),   // value
        .o_m_axis_tuser  (m_tuser)    // failed
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog: covers the clearing pass plus 600+ items at their worst, many times over
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) board.check_result(m_tdata, m_tuser[0]);
    end

    function automatic int draw_gap(ref bit calm);
        if ($urandom_range(0, 99) < 6) calm = !calm;
        return calm ? 0 : $urandom_range(0, 17);
    endfunction

    task automatic send_item(logic [2:0] kind, logic [31:0] addr, logic [31:0] wdata,
                             logic [31:0] count);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_tdata <= {count, wdata, addr};
        s_tuser <= kind;
        do @(posedge clk); while (!s_ready);
        board.note_item(kind, addr, wdata, count);
        items_sent++;
    endtask

    task automatic run_receiver();
        int gap;
        forever begin
            gap = draw_gap(recv_calm);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_ready <= 1'b1;
            do @(posedge clk); while (!m_valid);
        end
    endtask

    // mostly addresses already written, some fresh, some at the edges, some far out of range
    function automatic logic [31:0] pick_addr();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60 && written_addrs.size() > 0)
            return written_addrs[$urandom_range(0, written_addrs.size() - 1)];
        if (roll < 80) return $urandom_range(0, MEM_WORDS - 1);
        if (roll < 88) begin
            case ($urandom_range(0, 2))
                0: return 32'd0;
                1: return MEM_WORDS - 1;
                default: return MEM_WORDS;
            endcase
        end
        return $urandom();
    endfunction

    task automatic memory_burst();
        int          n;
        logic [31:0] addr;
        n = $urandom_range(2, 10);
        repeat (n) begin
            addr = pick_addr();
            if ($urandom_range(0, 1)) begin
                send_item(KIND_WRITE, addr, $urandom(), $urandom());
                if (addr < MEM_WORDS) begin
                    written_addrs.push_back(addr);
                    if (written_addrs.size() > 16) void'(written_addrs.pop_front());
                end
            end else begin
                send_item(KIND_READ, addr, $urandom(), $urandom());
            end
        end
    endtask

    // long runs can exhaust the map, short ones exercise the lowest-free search after frees
    task automatic alloc_burst();
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 8);
        repeat (n) send_item(KIND_ALLOC, $urandom(), $urandom(), $urandom());
        if ($urandom_range(0, 2) == 0)
            send_item(KIND_RESET_MAP, $urandom(), $urandom(), $urandom());
    endtask

    task automatic reserve_run();
        int          n;
        int          roll;
        logic [31:0] count;
        n = $urandom_range(1, 6);
        repeat (n) begin
            roll = $urandom_range(0, 99);
            if (roll < 75) count = $urandom_range(0, 4);
            else if (roll < 82) count = $urandom_range(0, 600);
            else if (roll < 92) count = $urandom();
            else if (items_sent > 450) count = board.table_room() + $urandom_range(0, 1);
            else count = 32'hffff_ffff - $urandom_range(0, 3);
            send_item(KIND_RESERVE, $urandom(), $urandom(), count);
        end
    endtask

    task automatic noise_items();
        repeat ($urandom_range(1, 4))
            send_item(3'($urandom_range(0, KIND_LAST_CODE)), $urandom(), $urandom(),
                      $urandom());
    endtask

    initial begin
        rst_n   <= 1'b0;
        s_valid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= KIND_READ;
        m_ready <= 1'b0;
        items_sent = 0;
        send_calm = 0;
        recv_calm = 0;
        board = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        fork
            run_receiver();
        join_none

        // directed: address edges, all kinds, table bounds, map exhaustion
        send_item(KIND_READ, 32'd0, 32'd0, 32'd0);
        send_item(KIND_WRITE, 32'd0, 32'hffff_ffff, 32'd0);
        send_item(KIND_READ, 32'd0, 32'd0, 32'd0);
        send_item(KIND_WRITE, MEM_WORDS - 1, 32'ha5a5_5a5a, 32'hffff_ffff);
        send_item(KIND_READ, MEM_WORDS - 1, 32'hffff_ffff, 32'hffff_ffff);
        send_item(KIND_READ, MEM_WORDS, 32'd0, 32'd0);
        send_item(KIND_WRITE, MEM_WORDS, 32'h1234_5678, 32'd0);
        send_item(KIND_WRITE, 32'hffff_ffff, 32'h0, 32'd0);
        send_item(KIND_READ, 32'h8000_0000, 32'd0, 32'd0);
        send_item(KIND_ALLOC, 32'd0, 32'd0, 32'd0);
        send_item(KIND_ALLOC, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_item(KIND_RESET_MAP, 32'd0, 32'd0, 32'd0);
        send_item(KIND_ALLOC, 32'd0, 32'd0, 32'd0);
        send_item(KIND_RESERVE, 32'd0, 32'd0, 32'd0);
        send_item(KIND_RESERVE, 32'd0, 32'd0, 32'd1);
        send_item(KIND_RESERVE, 32'd0, 32'd0, 32'hffff_ffff);
        send_item(KIND_RESERVE, 32'd0, 32'd0, KERNEL_TABLE_WORDS);
        send_item(KIND_RESERVE, 32'd0, 32'd0, KERNEL_TABLE_WORDS - 1 - 8);
        for (logic [2:0] k = KIND_RESET_MAP + 3'd1; k <= KIND_LAST_CODE && k != 0; k++)
            send_item(k, 32'd5, 32'hdead_beef, 32'd3);
        // no free frame: fill the whole map, then one more
        repeat (FRAME_COUNT - KERNEL_FRAMES) send_item(KIND_ALLOC, 32'd0, 32'd0, 32'd0);
        send_item(KIND_RESET_MAP, 32'd0, 32'd0, 32'd0);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: memory_burst();
                5, 6:          alloc_burst();
                7, 8:          reserve_run();
                default:       noise_items();
            endcase
        end
        s_valid <= 1'b0;

        while (board.pending() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (board.pending() != 0) board.report_mismatch("results still missing at end");
        if (board.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
